FILE: rtl/lkrc_pkg.sv
// Shared constants, types and opcodes for the keyed LRU result cache.
package lkrc_pkg;

    localparam int ENTRIES      = 16;
    localparam int NODE_BITS    = 32;
    localparam int PAYLOAD_BITS = 32;

    localparam int NODE_PORT_W = 32;
    localparam int PAY_PORT_W  = 32;
    localparam int REV_W       = 64;
    localparam int CAP_W       = 5;
    localparam int OCC_W       = 5;
    localparam int CTR_W       = 32;
    localparam int OP_W        = 2;

    localparam int NODE_W = (NODE_BITS < NODE_PORT_W) ? NODE_BITS : NODE_PORT_W;
    localparam int PAY_W  = (PAYLOAD_BITS < PAY_PORT_W) ? PAYLOAD_BITS : PAY_PORT_W;
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [OP_W-1:0] OP_GET   = 2'd0;
    localparam logic [OP_W-1:0] OP_PUT   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [NODE_W-1:0] start_node;
        logic [NODE_W-1:0] goal_node;
        logic [REV_W-1:0]  revision;
        logic [PAY_W-1:0]  payload_in;
    } item_t;

    typedef struct packed {
        logic                  hit;
        logic [PAY_PORT_W-1:0] payload_out;
        logic                  evicted;
        logic [OCC_W-1:0]      occupancy;
        logic [CTR_W-1:0]      hit_total;
        logic [CTR_W-1:0]      miss_total;
        logic [CTR_W-1:0]      eviction_total;
    } result_t;

endpackage

FILE: rtl/lkrc_in_stage.sv
// Input register stage that holds one accepted word for the cache core.
module lkrc_in_stage
    import lkrc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_W-1:0]        s_opcode,
    input  logic [NODE_PORT_W-1:0] s_start_node,
    input  logic [NODE_PORT_W-1:0] s_goal_node,
    input  logic [REV_W-1:0]       s_revision,
    input  logic [PAY_PORT_W-1:0]  s_payload_in,
    input  logic                   advance,
    output logic                   fire,
    output item_t                  item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_ready = !valid_reg || advance;
    assign fire    = valid_reg && advance;
    assign item    = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.opcode     <= s_opcode;
            item_reg.start_node <= s_start_node[NODE_W-1:0];
            item_reg.goal_node  <= s_goal_node[NODE_W-1:0];
            item_reg.revision   <= s_revision;
            item_reg.payload_in <= s_payload_in[PAY_W-1:0];
        end
    end

endmodule

FILE: rtl/lkrc_core.sv
// Cache entries, recency ranks, counters and the combinational lookup and update logic.
module lkrc_core
    import lkrc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CAP_W-1:0] capacity,
    input  logic             fire,
    input  item_t            item,
    output result_t          result
);

    logic [ENTRIES-1:0] valid_reg;
    logic [NODE_W-1:0]  start_reg [ENTRIES];
    logic [NODE_W-1:0]  goal_reg [ENTRIES];
    logic [REV_W-1:0]   rev_reg [ENTRIES];
    logic [PAY_W-1:0]   pay_reg [ENTRIES];
    logic [IDX_W-1:0]   rank_reg [ENTRIES];
    logic [CNT_W-1:0]   live_reg;
    logic [CTR_W-1:0]   hits_reg;
    logic [CTR_W-1:0]   misses_reg;
    logic [CTR_W-1:0]   evicts_reg;

    logic [ENTRIES-1:0] valid_next;
    logic [IDX_W-1:0]   rank_next [ENTRIES];
    logic [CNT_W-1:0]   live_next;
    logic [CTR_W-1:0]   hits_next;
    logic [CTR_W-1:0]   misses_next;
    logic [CTR_W-1:0]   evicts_next;
    logic [ENTRIES-1:0] key_we;
    logic [ENTRIES-1:0] pay_we;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] victim;
    logic [ENTRIES-1:0] kept;
    logic [ENTRIES-1:0] slot;
    logic               hit_any;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   hit_rank;
    logic [IDX_W-1:0]   lru_rank;
    logic [CNT_W-1:0]   eff_cap;
    logic               need_evict;
    logic               res_hit;
    logic               res_evicted;
    logic [PAY_W-1:0]   res_pay;

    function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] c);
        return (c == {CTR_W{1'b1}}) ? c : c + CTR_W'(1);
    endfunction

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = valid_reg[i] && (start_reg[i] == item.start_node)
                       && (goal_reg[i] == item.goal_node) && (rev_reg[i] == item.revision);
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
        hit_any  = |match;
        hit_rank = rank_reg[hit_idx];

        if (capacity == '0) begin
            eff_cap = CNT_W'(1);
        end else if (32'(capacity) > ENTRIES) begin
            eff_cap = CNT_W'(ENTRIES);
        end else begin
            eff_cap = CNT_W'(capacity);
        end
        need_evict = (live_reg >= eff_cap);
        lru_rank   = IDX_W'(live_reg - CNT_W'(1));

        for (int i = 0; i < ENTRIES; i++) begin
            victim[i] = valid_reg[i] && (rank_reg[i] == lru_rank);
        end
        kept = need_evict ? (valid_reg & ~victim) : valid_reg;

        slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!kept[i]) begin
                slot    = '0;
                slot[i] = 1'b1;
            end
        end

        valid_next  = valid_reg;
        live_next   = live_reg;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        evicts_next = evicts_reg;
        key_we      = '0;
        pay_we      = '0;
        res_hit     = 1'b0;
        res_evicted = 1'b0;
        res_pay     = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            rank_next[i] = rank_reg[i];
        end

        unique case (item.opcode) inside
            OP_GET, OP_PUT: begin
                if (hit_any) begin
                    res_hit = 1'b1;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (match[i]) begin
                            rank_next[i] = '0;
                        end else if (valid_reg[i] && (rank_reg[i] < hit_rank)) begin
                            rank_next[i] = rank_reg[i] + IDX_W'(1);
                        end
                    end
                    if (item.opcode == OP_GET) begin
                        res_pay   = pay_reg[hit_idx];
                        hits_next = sat_inc(hits_reg);
                    end else begin
                        pay_we = match;
                    end
                end else if (item.opcode == OP_GET) begin
                    misses_next = sat_inc(misses_reg);
                end else begin
                    res_evicted = need_evict;
                    if (need_evict) begin
                        evicts_next = sat_inc(evicts_reg);
                    end else begin
                        live_next = live_reg + CNT_W'(1);
                    end
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot[i]) begin
                            rank_next[i] = '0;
                        end else if (kept[i]) begin
                            rank_next[i] = rank_reg[i] + IDX_W'(1);
                        end
                    end
                    valid_next = kept | slot;
                    key_we     = slot;
                    pay_we     = slot;
                end
            end
            OP_CLEAR: begin
                valid_next = '0;
                live_next  = '0;
            end
            default: begin
            end
        endcase

        result.hit            = res_hit;
        result.payload_out    = PAY_PORT_W'(res_pay);
        result.evicted        = res_evicted;
        result.occupancy      = OCC_W'(live_next);
        result.hit_total      = hits_next;
        result.miss_total     = misses_next;
        result.eviction_total = evicts_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            live_reg   <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            evicts_reg <= '0;
        end else if (fire) begin
            valid_reg  <= valid_next;
            live_reg   <= live_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            evicts_reg <= evicts_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (fire) begin
                rank_reg[i] <= rank_next[i];
            end
            if (fire && key_we[i]) begin
                start_reg[i] <= item.start_node;
                goal_reg[i]  <= item.goal_node;
                rev_reg[i]   <= item.revision;
            end
            if (fire && pay_we[i]) begin
                pay_reg[i] <= item.payload_in;
            end
        end
    end

endmodule

FILE: rtl/lkrc_out_stage.sv
// Result register stage that holds one finished word until it is taken.
module lkrc_out_stage
    import lkrc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result_in,
    output logic    advance,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t result_out
);

    logic    valid_reg;
    result_t result_reg;

    assign advance    = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign result_out = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

endmodule

FILE: rtl/lru_keyed_result_cache.sv
// Top level of the fully associative keyed result cache with LRU replacement.
// Words pass an input register and a result register; lookup, replacement and rank
// update are combinational. Throughput: one word per cycle unless m_ready stalls.
// Reset (aresetn low, synchronous) empties the cache, zeroes the counters and sets
// the capacity register to 16. Entry contents need no clearing pass.
module lru_keyed_result_cache
    import lkrc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_capacity,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_W-1:0]        s_opcode,
    input  logic [NODE_PORT_W-1:0] s_start_node,
    input  logic [NODE_PORT_W-1:0] s_goal_node,
    input  logic [REV_W-1:0]       s_revision,
    input  logic [PAY_PORT_W-1:0]  s_payload_in,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_hit,
    output logic [PAY_PORT_W-1:0]  m_payload_out,
    output logic                   m_evicted,
    output logic [OCC_W-1:0]       m_occupancy,
    output logic [CTR_W-1:0]       m_hit_total,
    output logic [CTR_W-1:0]       m_miss_total,
    output logic [CTR_W-1:0]       m_eviction_total
);

    logic             cap_we;
    logic [CAP_W-1:0] cap_reg;
    logic             advance;
    logic             fire;
    item_t            item;
    result_t          core_result;
    result_t          out_result;

    assign cfg_ready = 1'b1;
    assign cap_we    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cap_we) begin
            cap_reg <= cfg_capacity;
        end
    end

    lkrc_in_stage u_in_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_start_node (s_start_node),
        .s_goal_node  (s_goal_node),
        .s_revision   (s_revision),
        .s_payload_in (s_payload_in),
        .advance      (advance),
        .fire         (fire),
        .item         (item)
    );

    lkrc_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .capacity (cap_reg),
        .fire     (fire),
        .item     (item),
        .result   (core_result)
    );

    lkrc_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire),
        .result_in  (core_result),
        .advance    (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result_out (out_result)
    );

    assign m_hit            = out_result.hit;
    assign m_payload_out    = out_result.payload_out;
    assign m_evicted        = out_result.evicted;
    assign m_occupancy      = out_result.occupancy;
    assign m_hit_total      = out_result.hit_total;
    assign m_miss_total     = out_result.miss_total;
    assign m_eviction_total = out_result.eviction_total;

endmodule
